### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/pid3m_pkg.sv
// ----------------------------------------------------------------------------
// pid3m_pkg
// types and constants of the three-mode pid controller
// ----------------------------------------------------------------------------
package pid3m_pkg;

   typedef enum logic [1:0] {
      MODE_INC    = 2'd0,
      MODE_POS    = 2'd1,
      MODE_POS_FF = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 32;

   localparam logic [CsrIndexWidth-1:0] CSR_MODE      = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_GAIN_P    = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_GAIN_I    = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_GAIN_D    = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_GAIN_F    = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_INT_LIMIT = 3'd5;
   localparam logic [CsrIndexWidth-1:0] CSR_OUT_LIMIT = 3'd6;

   // gains are signed q16.16
   localparam int unsigned QShift = 16;

   localparam logic [14:0] OUT_LIMIT_RESET = 15'h7fff;

endpackage

### src/pid_controller_three_mode_unit.sv
// ----------------------------------------------------------------------------
// pid_controller_three_mode_unit
// pid drive controller: incremental, positional, positional with feedforward
// ----------------------------------------------------------------------------
// Takes one item (measured, target) per clock unless stalled and returns one
// saturated drive value per item, in order, from the output register. The
// operand stage updates the controller state (error history, clamped error
// sum, last target) in the cycle an item is accepted, so back-to-back items
// see each other's state; the product stage does four independent signed
// multiplies, the term stage clamps the mode 0 integral term and adds the
// other terms, and the output register adds and saturates to +-out limit.
// Each stage stalls only when the one after it is full, so up to three more
// items are taken while a result waits. Configuration writes are taken every
// cycle and should be made with no item in flight.
`include "assert_macros.svh"

module pid_controller_three_mode_unit (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_ready,
   input  logic signed [15:0]                          req_measured,
   input  logic signed [15:0]                          req_target,
   output logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   output logic signed [15:0]                          rsp_drive,
   input  logic                                        csr_valid,
   output logic                                        csr_ready,
   input  logic [pid3m_pkg::CsrIndexWidth-1:0]         csr_index,
   input  logic [pid3m_pkg::CsrDataWidth-1:0]          csr_data
);

   // configuration
   pid3m_pkg::mode_type mode_ff;
   logic signed [31:0]  gain_p_ff, gain_i_ff, gain_d_ff, gain_f_ff;
   logic [30:0]         int_limit_ff;
   logic [14:0]         out_limit_ff;

   // controller state
   logic signed [16:0]  prev_error_ff, prev_error_in;
   logic signed [16:0]  prev_prev_error_ff, prev_prev_error_in;
   logic signed [31:0]  error_sum_ff, error_sum_in;
   logic signed [15:0]  prev_target_ff, prev_target_in;

   // operand stage
   logic                s1_valid_ff;
   logic                s1_inc_ff, s1_inc_in;
   logic signed [17:0]  op_p_ff, op_p_in;
   logic signed [31:0]  op_i_ff, op_i_in;
   logic signed [18:0]  op_d_ff, op_d_in;
   logic signed [16:0]  op_f_ff, op_f_in;

   // product stage, products already shifted by the q point
   logic                s2_valid_ff;
   logic                s2_inc_ff;
   logic signed [33:0]  prod_p_ff;
   logic signed [47:0]  prod_i_ff;
   logic signed [34:0]  prod_d_ff;
   logic signed [32:0]  prod_f_ff;
   logic signed [49:0]  mul_p;
   logic signed [63:0]  mul_i;
   logic signed [50:0]  mul_d;
   logic signed [48:0]  mul_f;

   // term stage
   logic                s3_valid_ff;
   logic signed [47:0]  term_i_ff, term_i_in;
   logic signed [35:0]  term_pdf_ff, term_pdf_in;

   // output register
   logic                rsp_valid_ff;
   logic signed [15:0]  drive_ff, drive_in;
   logic signed [49:0]  total;

   logic                out_free, s3_free, s2_free, s1_free;
   logic                req_accept;
   logic signed [16:0]  err;
   logic signed [32:0]  sum_raw;
   logic signed [32:0]  ilim33;
   logic signed [47:0]  ilim48;
   logic signed [49:0]  olim50;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign s3_free    = !s3_valid_ff || out_free;
   assign s2_free    = !s2_valid_ff || s3_free;
   assign s1_free    = !s1_valid_ff || s2_free;
   assign req_ready  = s1_free;
   assign req_accept = req_valid && s1_free;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_drive  = drive_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= pid3m_pkg::MODE_POS;
         gain_p_ff    <= '0;
         gain_i_ff    <= '0;
         gain_d_ff    <= '0;
         gain_f_ff    <= '0;
         int_limit_ff <= '0;
         out_limit_ff <= pid3m_pkg::OUT_LIMIT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            pid3m_pkg::CSR_MODE:      mode_ff      <= pid3m_pkg::mode_type'(csr_data[1:0]);
            pid3m_pkg::CSR_GAIN_P:    gain_p_ff    <= $signed(csr_data);
            pid3m_pkg::CSR_GAIN_I:    gain_i_ff    <= $signed(csr_data);
            pid3m_pkg::CSR_GAIN_D:    gain_d_ff    <= $signed(csr_data);
            pid3m_pkg::CSR_GAIN_F:    gain_f_ff    <= $signed(csr_data);
            pid3m_pkg::CSR_INT_LIMIT: int_limit_ff <= csr_data[30:0];
            pid3m_pkg::CSR_OUT_LIMIT: out_limit_ff <= csr_data[14:0];
            default: ;
         endcase
      end
   end

   assign ilim33 = $signed({2'b00, int_limit_ff});
   assign ilim48 = $signed({17'd0, int_limit_ff});
   assign olim50 = $signed({35'd0, out_limit_ff});

   // operand stage: error, state update and multiplier operands
   assign err     = 17'(req_target) - 17'(req_measured);
   assign sum_raw = 33'(error_sum_ff) + 33'(err);

   always_comb begin
      prev_error_in      = prev_error_ff;
      prev_prev_error_in = prev_prev_error_ff;
      error_sum_in       = error_sum_ff;
      prev_target_in     = prev_target_ff;
      s1_inc_in          = 1'b0;
      op_p_in            = '0;
      op_i_in            = '0;
      op_d_in            = '0;
      op_f_in            = '0;
      case (mode_ff)
         pid3m_pkg::MODE_INC: begin
            s1_inc_in          = 1'b1;
            op_p_in            = 18'(err) - 18'(prev_error_ff);
            op_i_in            = 32'(err);
            op_d_in            = 19'(err) - (19'(prev_error_ff) <<< 1) + 19'(prev_prev_error_ff);
            prev_prev_error_in = prev_error_ff;
            prev_error_in      = err;
         end
         pid3m_pkg::MODE_POS, pid3m_pkg::MODE_POS_FF: begin
            // error sum is clamped to +-int limit before use
            if (sum_raw > ilim33) begin
               error_sum_in = 32'(ilim33);
            end else if (sum_raw < -ilim33) begin
               error_sum_in = 32'(-ilim33);
            end else begin
               error_sum_in = 32'(sum_raw);
            end
            op_p_in       = 18'(err);
            op_i_in       = error_sum_in;
            op_d_in       = 19'(err) - 19'(prev_error_ff);
            prev_error_in = err;
            if (mode_ff == pid3m_pkg::MODE_POS_FF) begin
               op_f_in        = 17'(req_target) - 17'(prev_target_ff);
               prev_target_in = req_target;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_error_ff      <= '0;
         prev_prev_error_ff <= '0;
         error_sum_ff       <= '0;
         prev_target_ff     <= '0;
      end else if (req_accept) begin
         prev_error_ff      <= prev_error_in;
         prev_prev_error_ff <= prev_prev_error_in;
         error_sum_ff       <= error_sum_in;
         prev_target_ff     <= prev_target_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_inc_ff <= s1_inc_in;
         op_p_ff   <= op_p_in;
         op_i_ff   <= op_i_in;
         op_d_ff   <= op_d_in;
         op_f_ff   <= op_f_in;
      end
   end

   // product stage
   assign mul_p = 50'(gain_p_ff) * 50'(op_p_ff);
   assign mul_i = 64'(gain_i_ff) * 64'(op_i_ff);
   assign mul_d = 51'(gain_d_ff) * 51'(op_d_ff);
   assign mul_f = 49'(gain_f_ff) * 49'(op_f_ff);

   always_ff @(posedge clock) begin
      if (s2_free && s1_valid_ff) begin
         s2_inc_ff <= s1_inc_ff;
         // arithmetic shift: rounds toward minus infinity
         prod_p_ff <= mul_p[49:pid3m_pkg::QShift];
         prod_i_ff <= mul_i[63:pid3m_pkg::QShift];
         prod_d_ff <= mul_d[50:pid3m_pkg::QShift];
         prod_f_ff <= mul_f[48:pid3m_pkg::QShift];
      end
   end

   // term stage: incremental mode clamps the integral term on its own
   always_comb begin
      term_i_in = prod_i_ff;
      if (s2_inc_ff) begin
         if (prod_i_ff > ilim48) begin
            term_i_in = ilim48;
         end else if (prod_i_ff < -ilim48) begin
            term_i_in = -ilim48;
         end
      end
      term_pdf_in = 36'(prod_p_ff) + 36'(prod_d_ff) + 36'(prod_f_ff);
   end

   always_ff @(posedge clock) begin
      if (s3_free && s2_valid_ff) begin
         term_i_ff   <= term_i_in;
         term_pdf_ff <= term_pdf_in;
      end
   end

   // output register: final sum and saturation
   assign total = 50'(term_pdf_ff) + 50'(term_i_ff);

   always_comb begin
      if (total > olim50) begin
         drive_in = 16'(olim50);
      end else if (total < -olim50) begin
         drive_in = 16'(-olim50);
      end else begin
         drive_in = 16'(total);
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s3_valid_ff) begin
         drive_ff <= drive_in;
      end
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_free) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_free) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_free) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (out_free) begin
            rsp_valid_ff <= s3_valid_ff;
         end
      end
   end

   `ASSERT_IMPLIES(a_drive_in_limit, clock, reset, rsp_valid_ff,
      (17'(drive_ff) <= 17'(olim50)) && (17'(drive_ff) >= -17'(olim50)),
      "drive outside output limit")
   `ASSERT_IMPLIES(a_stall_only_when_full, clock, reset, !req_ready,
      s1_valid_ff && s2_valid_ff && s3_valid_ff && rsp_valid_ff,
      "input stalled with a free pipeline slot")
   `ASSERT_NEXT(a_unused_mode_holds_state, clock, reset,
      req_accept && (mode_ff == pid3m_pkg::MODE_NONE),
      $stable(error_sum_ff) && $stable(prev_error_ff) && $stable(prev_target_ff),
      "unused mode changed controller state")
   `ASSERT_NEXT(a_inc_error_history, clock, reset,
      req_accept && (mode_ff == pid3m_pkg::MODE_INC),
      prev_prev_error_ff == $past(prev_error_ff),
      "error history not shifted in incremental mode")

endmodule
